[rtl/pnis_pkg.sv]
`timescale 1ns / 1ps

package pnis_pkg;

  localparam logic [1:0] FN_ADD    = 2'd0;
  localparam logic [1:0] FN_REMOVE = 2'd1;
  localparam logic [1:0] FN_QUERY  = 2'd2;
  localparam logic [1:0] FN_DROP   = 2'd3;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] first_number;
    logic [63:0] end_number;
  } req_t;

  typedef struct packed {
    logic        flag;
    logic [1:0]  status;
    logic [6:0]  interval_count;
    logic [63:0] lowest_number;
    logic [63:0] highest_number;
    logic [63:0] newest_length;
  } rsp_t;

endpackage

[rtl/pnis_ram.sv]
`timescale 1ns / 1ps

module pnis_ram #(
  parameter int WIDTH  = 128,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/packet_number_interval_set.sv]
`timescale 1ns / 1ps

// Channel   Direction  Signals
// request   in         in_valid_i, in_ready_o, in_req_i
// response  out        out_valid_o, out_ready_i, out_rsp_o
//
// One request is in work at a time; the interval store is a single RAM with
// registered read, so every entry visit is an address step and a data step.
// A valid add scans forward and backward, then shifts and inserts or merges
// and compacts. A query scans every entry; a remove scans and compacts; a drop
// only compacts. Unless the store ends empty, each request then reads the
// lowest and highest entry.
// Reset clears the state, the interval count and the response valid; no clearing pass is needed.
// A pending response does not block acceptance, only the next completion.

module packet_number_interval_set #(
  parameter int MAX_INTERVALS = 64,
  parameter int SEQ_BITS      = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  pnis_pkg::req_t     in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output pnis_pkg::rsp_t     out_rsp_o
);

  localparam int AW = $clog2(MAX_INTERVALS);
  localparam int CW = $clog2(MAX_INTERVALS + 1);
  localparam int SB = SEQ_BITS;

  typedef enum logic [4:0] {
    S_IDLE, S_AF_RD, S_AF_EV, S_AB_RD, S_AB_EV, S_DECIDE, S_SH_RD, S_SH_EV,
    S_WR_INS, S_WR_MRG, S_CP_CHK, S_CP_RD, S_CP_EV, S_RM_RD, S_RM_EV,
    S_QY_RD, S_QY_EV, S_O0_RD, S_O0_EV, S_O1_RD, S_O1_EV, S_DONE
  } state_e;

  function automatic logic ser_lt(logic [SB-1:0] a, logic [SB-1:0] b);
    logic [SB-1:0] d;
    d = a - b;
    return (a != b) && d[SB-1];
  endfunction

  state_e          state_q, state_d;
  logic [1:0]      func_q, func_d;
  logic [SB-1:0]   lo_q, lo_d, hi_q, hi_d;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   idx_q, idx_d, first_q, first_d, last_q, last_d, n_q, n_d;
  logic            found_q, found_d;
  logic [SB-1:0]   sfirst_q, sfirst_d, slast_q, slast_d, old_min_q, old_min_d;
  logic [SB-1:0]   low_q, low_d, high_q, high_d, len_q, len_d;
  logic            flag_q, flag_d;
  logic [1:0]      status_q, status_d;
  logic            out_valid_q, out_valid_d;
  pnis_pkg::rsp_t  out_q, out_d;

  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [2*SB-1:0] wdata, rdata;
  logic [SB-1:0]   rd_start, rd_stop, ns, ne;
  logic [CW:0]     cp_src;
  logic [CW-1:0]   cnt_new;

  assign rd_start = rdata[2*SB-1:SB];
  assign rd_stop  = rdata[SB-1:0];
  assign cp_src   = {1'b0, idx_q} + {1'b0, n_q};
  assign ns       = ser_lt(sfirst_q, lo_q) ? sfirst_q : lo_q;
  assign ne       = ser_lt(hi_q, slast_q) ? slast_q : hi_q;
  assign cnt_new  = count_q - n_q;

  pnis_ram #(
    .WIDTH (2 * SB),
    .DEPTH (MAX_INTERVALS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  always_comb begin
    state_d     = state_q;
    func_d      = func_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    count_d     = count_q;
    idx_d       = idx_q;
    first_d     = first_q;
    last_d      = last_q;
    n_d         = n_q;
    found_d     = found_q;
    sfirst_d    = sfirst_q;
    slast_d     = slast_q;
    old_min_d   = old_min_q;
    low_d       = low_q;
    high_d      = high_q;
    len_d       = len_q;
    flag_d      = flag_q;
    status_d    = status_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    we          = 1'b0;
    waddr       = idx_q[AW-1:0];
    wdata       = rdata;
    raddr       = idx_q[AW-1:0];

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          func_d   = in_req_i.func;
          lo_d     = in_req_i.first_number[SB-1:0];
          hi_d     = in_req_i.end_number[SB-1:0];
          flag_d   = 1'b0;
          status_d = pnis_pkg::ST_DONE;
          found_d  = 1'b0;
          idx_d    = '0;
          case (in_req_i.func)
            pnis_pkg::FN_ADD: begin
              if (!ser_lt(in_req_i.first_number[SB-1:0], in_req_i.end_number[SB-1:0])) begin
                status_d = pnis_pkg::ST_IGNORED;
                state_d  = (count_q == '0) ? S_DONE : S_O0_RD;
              end else if (count_q == '0) begin
                first_d = '0;
                state_d = S_DECIDE;
              end else begin
                state_d = S_AF_RD;
              end
            end
            pnis_pkg::FN_REMOVE: begin
              state_d = (count_q == '0) ? S_DONE : S_RM_RD;
            end
            pnis_pkg::FN_QUERY: begin
              state_d = (count_q == '0) ? S_DONE : S_QY_RD;
            end
            default: begin
              if (count_q >= CW'(2)) begin
                n_d     = CW'(1);
                state_d = S_CP_CHK;
              end else begin
                status_d = pnis_pkg::ST_IGNORED;
                state_d  = (count_q == '0) ? S_DONE : S_O0_RD;
              end
            end
          endcase
        end
      end
      S_AF_RD: begin
        state_d = S_AF_EV;
      end
      S_AF_EV: begin
        if (!ser_lt(rd_stop, lo_q)) begin
          first_d  = idx_q;
          sfirst_d = rd_start;
          idx_d    = count_q - CW'(1);
          state_d  = S_AB_RD;
        end else if (idx_q + CW'(1) == count_q) begin
          first_d = count_q;
          idx_d   = count_q - CW'(1);
          state_d = S_AB_RD;
        end else begin
          idx_d   = idx_q + CW'(1);
          state_d = S_AF_RD;
        end
      end
      S_AB_RD: begin
        state_d = S_AB_EV;
      end
      S_AB_EV: begin
        if (!ser_lt(hi_q, rd_start)) begin
          found_d = 1'b1;
          last_d  = idx_q;
          slast_d = rd_stop;
          state_d = S_DECIDE;
        end else if (idx_q == '0) begin
          state_d = S_DECIDE;
        end else begin
          idx_d   = idx_q - CW'(1);
          state_d = S_AB_RD;
        end
      end
      S_DECIDE: begin
        if (!found_q || (last_q < first_q)) begin
          if (count_q >= CW'(MAX_INTERVALS)) begin
            status_d = pnis_pkg::ST_FULL;
            state_d  = S_O0_RD;
          end else begin
            idx_d   = count_q;
            state_d = (count_q > first_q) ? S_SH_RD : S_WR_INS;
          end
        end else begin
          state_d = S_WR_MRG;
        end
      end
      S_SH_RD: begin
        raddr   = AW'(idx_q - CW'(1));
        state_d = S_SH_EV;
      end
      S_SH_EV: begin
        we      = 1'b1;
        waddr   = idx_q[AW-1:0];
        idx_d   = idx_q - CW'(1);
        state_d = ((idx_q - CW'(1)) > first_q) ? S_SH_RD : S_WR_INS;
      end
      S_WR_INS: begin
        we      = 1'b1;
        waddr   = first_q[AW-1:0];
        wdata   = {lo_q, hi_q};
        count_d = count_q + CW'(1);
        state_d = S_O0_RD;
      end
      S_WR_MRG: begin
        we      = 1'b1;
        waddr   = first_q[AW-1:0];
        wdata   = {ns, ne};
        idx_d   = first_q + CW'(1);
        n_d     = last_q - first_q;
        state_d = S_CP_CHK;
      end
      S_CP_CHK: begin
        if (cp_src < {1'b0, count_q}) begin
          state_d = S_CP_RD;
        end else begin
          count_d = cnt_new;
          if (cnt_new == '0) begin
            if (func_q == pnis_pkg::FN_REMOVE) begin
              flag_d = 1'b1;
            end
            state_d = S_DONE;
          end else begin
            state_d = S_O0_RD;
          end
        end
      end
      S_CP_RD: begin
        raddr   = cp_src[AW-1:0];
        state_d = S_CP_EV;
      end
      S_CP_EV: begin
        we      = 1'b1;
        waddr   = idx_q[AW-1:0];
        idx_d   = idx_q + CW'(1);
        state_d = S_CP_CHK;
      end
      S_RM_RD: begin
        state_d = S_RM_EV;
      end
      S_RM_EV: begin
        if (idx_q == '0) begin
          old_min_d = rd_start;
        end
        if (ser_lt(rd_stop, hi_q)) begin
          if (idx_q + CW'(1) == count_q) begin
            n_d     = count_q;
            idx_d   = '0;
            state_d = S_CP_CHK;
          end else begin
            idx_d   = idx_q + CW'(1);
            state_d = S_RM_RD;
          end
        end else if (ser_lt(rd_start, hi_q)) begin
          we      = 1'b1;
          waddr   = idx_q[AW-1:0];
          wdata   = {hi_q, rd_stop};
          n_d     = idx_q + CW'(rd_stop == hi_q);
          idx_d   = '0;
          state_d = S_CP_CHK;
        end else begin
          n_d     = idx_q;
          idx_d   = '0;
          state_d = S_CP_CHK;
        end
      end
      S_QY_RD: begin
        state_d = S_QY_EV;
      end
      S_QY_EV: begin
        if (!ser_lt(lo_q, rd_start) && ser_lt(lo_q, rd_stop)) begin
          flag_d = 1'b1;
        end
        if (idx_q + CW'(1) == count_q) begin
          state_d = S_O0_RD;
        end else begin
          idx_d   = idx_q + CW'(1);
          state_d = S_QY_RD;
        end
      end
      S_O0_RD: begin
        raddr   = '0;
        state_d = S_O0_EV;
      end
      S_O0_EV: begin
        low_d = rd_start;
        if (func_q == pnis_pkg::FN_REMOVE) begin
          flag_d = (rd_start != old_min_q);
        end
        state_d = S_O1_RD;
      end
      S_O1_RD: begin
        raddr   = AW'(count_q - CW'(1));
        state_d = S_O1_EV;
      end
      S_O1_EV: begin
        high_d  = rd_stop - SB'(1);
        len_d   = rd_stop - rd_start;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d          = 1'b1;
          out_d.flag           = flag_q;
          out_d.status         = status_q;
          out_d.interval_count = 7'(count_q);
          if (count_q == '0) begin
            out_d.lowest_number  = '0;
            out_d.highest_number = '0;
            out_d.newest_length  = '0;
          end else begin
            out_d.lowest_number  = 64'(low_q);
            out_d.highest_number = 64'(high_q);
            out_d.newest_length  = 64'(len_q);
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q    <= func_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    idx_q     <= idx_d;
    first_q   <= first_d;
    last_q    <= last_d;
    n_q       <= n_d;
    found_q   <= found_d;
    sfirst_q  <= sfirst_d;
    slast_q   <= slast_d;
    old_min_q <= old_min_d;
    low_q     <= low_d;
    high_q    <= high_d;
    len_q     <= len_d;
    flag_q    <= flag_d;
    status_q  <= status_d;
    out_q     <= out_d;
  end

endmodule

[rtl/pnis_checker.sv]
`timescale 1ns / 1ps

module pnis_checker #(
  parameter int MAX_INTERVALS = 64
) (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input pnis_pkg::rsp_t out_rsp_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("response changed while stalled");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.interval_count == 7'd0) |->
      (out_rsp_o.lowest_number == 64'd0) && (out_rsp_o.highest_number == 64'd0) &&
      (out_rsp_o.newest_length == 64'd0))
    else $error("empty set reports nonzero numbers");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.status == pnis_pkg::ST_FULL) |->
      (out_rsp_o.interval_count == 7'(MAX_INTERVALS)) && !out_rsp_o.flag)
    else $error("full drop with store not full");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_rsp_o.status == pnis_pkg::ST_DONE) ||
      (out_rsp_o.status == pnis_pkg::ST_FULL) || (out_rsp_o.status == pnis_pkg::ST_IGNORED))
    else $error("undefined status code");

endmodule

bind packet_number_interval_set pnis_checker #(
  .MAX_INTERVALS (MAX_INTERVALS)
) u_pnis_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_o   (out_rsp_o)
);

[verif/pnis_checker.sv]
`timescale 1ns / 1ps

module pnis_scoreboard (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_ready_i,
  input  pnis_pkg::req_t  in_req_i,
  input  logic            out_valid_i,
  input  logic            out_ready_i,
  input  pnis_pkg::rsp_t  out_rsp_i,
  output int              fail_count_o,
  output int              pending_o
);

  localparam int CAP = 64;
  localparam int FIFO_DEPTH = 16;

  logic [63:0]    lo_q [CAP];
  logic [63:0]    hi_q [CAP];
  int             cnt = 0;
  int             fails = 0;
  int             wr_cnt = 0;
  int             rd_cnt = 0;
  pnis_pkg::rsp_t exp_mem [FIFO_DEPTH];

  function automatic bit seq_lt(logic [63:0] a, logic [63:0] b);
    logic [63:0] d;
    d = a - b;
    return a != b && d[63];
  endfunction

  function automatic void shift_down(int pos, int n);
    for (int i = pos; i + n < cnt; i++) begin
      lo_q[i] = lo_q[i + n];
      hi_q[i] = hi_q[i + n];
    end
    cnt -= n;
  endfunction

  function automatic logic [1:0] merge_range(logic [63:0] a, logic [63:0] b);
    int first;
    int last;
    logic [63:0] ns;
    logic [63:0] ne;
    first = cnt;
    last = -1;
    if (!seq_lt(a, b)) return pnis_pkg::ST_IGNORED;
    for (int i = 0; i < cnt; i++) begin
      if (!seq_lt(hi_q[i], a)) begin
        first = i;
        break;
      end
    end
    for (int k = cnt; k > 0; k--) begin
      if (!seq_lt(b, lo_q[k - 1])) begin
        last = k - 1;
        break;
      end
    end
    if (last < first) begin
      if (cnt >= CAP) return pnis_pkg::ST_FULL;
      for (int k = cnt; k > first; k--) begin
        lo_q[k] = lo_q[k - 1];
        hi_q[k] = hi_q[k - 1];
      end
      lo_q[first] = a;
      hi_q[first] = b;
      cnt++;
      return pnis_pkg::ST_DONE;
    end
    ns = seq_lt(lo_q[first], a) ? lo_q[first] : a;
    ne = seq_lt(b, hi_q[last]) ? hi_q[last] : b;
    lo_q[first] = ns;
    hi_q[first] = ne;
    shift_down(first + 1, last - first);
    return pnis_pkg::ST_DONE;
  endfunction

  function automatic bit trim_below(logic [63:0] bound);
    logic [63:0] old_min;
    int drop;
    drop = 0;
    if (cnt == 0) return 0;
    old_min = lo_q[0];
    while (drop < cnt) begin
      if (seq_lt(hi_q[drop], bound)) begin
        drop++;
      end else if (seq_lt(lo_q[drop], bound)) begin
        lo_q[drop] = bound;
        if (hi_q[drop] == bound) drop++;
        break;
      end else begin
        break;
      end
    end
    shift_down(0, drop);
    return cnt == 0 || old_min != lo_q[0];
  endfunction

  function automatic bit holds(logic [63:0] p);
    for (int i = 0; i < cnt; i++) begin
      if (!seq_lt(p, lo_q[i]) && seq_lt(p, hi_q[i])) return 1;
    end
    return 0;
  endfunction

  function automatic pnis_pkg::rsp_t apply_request(pnis_pkg::req_t r);
    pnis_pkg::rsp_t o;
    o = '0;
    case (r.func)
      pnis_pkg::FN_ADD: o.status = merge_range(r.first_number, r.end_number);
      pnis_pkg::FN_REMOVE: o.flag = trim_below(r.end_number);
      pnis_pkg::FN_QUERY: o.flag = holds(r.first_number);
      default: begin
        if (cnt >= 2) shift_down(0, 1);
        else o.status = pnis_pkg::ST_IGNORED;
      end
    endcase
    o.interval_count = cnt[6:0];
    if (cnt != 0) begin
      o.lowest_number = lo_q[0];
      o.highest_number = hi_q[cnt - 1] - 64'd1;
      o.newest_length = hi_q[cnt - 1] - lo_q[cnt - 1];
    end
    return o;
  endfunction

  assign fail_count_o = fails;
  assign pending_o = wr_cnt - rd_cnt;

  always @(posedge clk_i) begin
    pnis_pkg::rsp_t e;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        if (wr_cnt - rd_cnt >= FIFO_DEPTH) begin
          $error("too many requests outstanding");
          fails++;
        end
        exp_mem[wr_cnt % FIFO_DEPTH] = apply_request(in_req_i);
        wr_cnt++;
      end
      if (out_valid_i && out_ready_i) begin
        if (wr_cnt == rd_cnt) begin
          $error("response with nothing expected");
          fails++;
        end else begin
          e = exp_mem[rd_cnt % FIFO_DEPTH];
          rd_cnt++;
          if (e.flag !== out_rsp_i.flag) begin
            $error("flag: expected %0h, got %0h", e.flag, out_rsp_i.flag);
            fails++;
          end
          if (e.status !== out_rsp_i.status) begin
            $error("status: expected %0h, got %0h", e.status, out_rsp_i.status);
            fails++;
          end
          if (e.interval_count !== out_rsp_i.interval_count) begin
            $error("interval_count: expected %0d, got %0d", e.interval_count,
                   out_rsp_i.interval_count);
            fails++;
          end
          if (e.lowest_number !== out_rsp_i.lowest_number) begin
            $error("lowest_number: expected %0h, got %0h", e.lowest_number,
                   out_rsp_i.lowest_number);
            fails++;
          end
          if (e.highest_number !== out_rsp_i.highest_number) begin
            $error("highest_number: expected %0h, got %0h", e.highest_number,
                   out_rsp_i.highest_number);
            fails++;
          end
          if (e.newest_length !== out_rsp_i.newest_length) begin
            $error("newest_length: expected %0h, got %0h", e.newest_length,
                   out_rsp_i.newest_length);
            fails++;
          end
        end
      end
    end
  end

endmodule

[verif/tb_packet_number_interval_set.sv]
`timescale 1ns / 1ps

module tb_packet_number_interval_set;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  pnis_pkg::req_t in_req;
  logic out_valid;
  logic out_ready;
  pnis_pkg::rsp_t out_rsp;
  int   fail_count;
  int   pending;
  bit   hold_off;
  bit   sender_done;
  logic [63:0] base_num;

  packet_number_interval_set u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_req_i(in_req),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_rsp_o(out_rsp)
  );

  pnis_scoreboard u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_req_i(in_req),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_rsp_i(out_rsp),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial clk = 0;
  always #10 clk = ~clk;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_request(logic [1:0] fn, logic [63:0] a, logic [63:0] b);
    in_req.func = fn;
    in_req.first_number = a;
    in_req.end_number = b;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_spaced(logic [1:0] fn, logic [63:0] a, logic [63:0] b);
    int g;
    send_request(fn, a, b);
    g = gap_len();
    repeat (g) @(negedge clk);
  endtask

  // Numbers cluster near a moving base so that intervals merge and touch.
  function automatic logic [63:0] near_num();
    return base_num + 64'($urandom_range(0, 400));
  endfunction

  task automatic random_request();
    int r;
    logic [63:0] a;
    logic [63:0] b;
    r = $urandom_range(0, 99);
    a = near_num();
    b = a + 64'($urandom_range(1, 6));
    if (r < 55) begin
      if ($urandom_range(0, 19) == 0) begin
        send_spaced(pnis_pkg::FN_ADD, {$urandom, $urandom}, {$urandom, $urandom});
      end else if ($urandom_range(0, 19) == 0) begin
        send_spaced(pnis_pkg::FN_ADD, b, a);
      end else begin
        send_spaced(pnis_pkg::FN_ADD, a, b);
      end
    end else if (r < 70) begin
      if ($urandom_range(0, 9) == 0) begin
        send_spaced(pnis_pkg::FN_REMOVE, a, {$urandom, $urandom});
      end else begin
        send_spaced(pnis_pkg::FN_REMOVE, a, base_num + 64'($urandom_range(0, 150)));
      end
      if ($urandom_range(0, 3) == 0) base_num = base_num + 64'($urandom_range(0, 100));
    end else if (r < 90) begin
      if ($urandom_range(0, 9) == 0) begin
        send_spaced(pnis_pkg::FN_QUERY, {$urandom, $urandom}, b);
      end else begin
        send_spaced(pnis_pkg::FN_QUERY, a, {$urandom, $urandom});
      end
    end else begin
      send_spaced(pnis_pkg::FN_DROP, {$urandom, $urandom}, {$urandom, $urandom});
    end
  endtask

  initial begin
    int hold;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
        hold = 3000;
        repeat (hold) @(negedge clk);
        hold_off = 0;
      end else if ($urandom_range(0, 2) == 0) begin
        hold = gap_len();
        if (hold > 0) begin
          out_ready <= 1'b0;
          repeat (hold) @(negedge clk);
        end
      end
      out_ready <= 1'b1;
    end
  end

  initial begin
    #100ms;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    logic [63:0] all1;
    all1 = '1;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req = '0;
    hold_off = 0;
    sender_done = 0;
    base_num = 64'hFFFF_FFFF_FFFF_FF00;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_request(pnis_pkg::FN_REMOVE, 64'd0, 64'd5);
    send_request(pnis_pkg::FN_QUERY, 64'd3, 64'd0);
    send_request(pnis_pkg::FN_DROP, 64'd0, 64'd0);
    send_request(pnis_pkg::FN_ADD, 64'd10, 64'd10);
    send_request(pnis_pkg::FN_ADD, 64'd20, 64'd10);
    send_request(pnis_pkg::FN_ADD, all1 - 64'd2, 64'd3);
    send_request(pnis_pkg::FN_ADD, 64'd3, 64'd4);
    send_request(pnis_pkg::FN_ADD, 64'd10, 64'd20);
    send_request(pnis_pkg::FN_ADD, 64'd20, 64'd25);
    send_request(pnis_pkg::FN_ADD, 64'd2, 64'd12);
    send_request(pnis_pkg::FN_QUERY, 64'd24, 64'd0);
    send_request(pnis_pkg::FN_QUERY, 64'd25, 64'd0);
    send_request(pnis_pkg::FN_QUERY, all1, 64'd0);
    send_request(pnis_pkg::FN_DROP, 64'd0, 64'd0);
    send_request(pnis_pkg::FN_ADD, 64'd40, 64'd50);
    send_request(pnis_pkg::FN_REMOVE, 64'd0, 64'd42);
    send_request(pnis_pkg::FN_REMOVE, 64'd0, 64'd50);
    send_request(pnis_pkg::FN_ADD, 64'h8000_0000_0000_0000, 64'd0);
    send_request(pnis_pkg::FN_ADD, 64'd0, 64'h8000_0000_0000_0000);
    send_request(pnis_pkg::FN_QUERY, 64'h4000_0000_0000_0000, 64'd0);
    send_request(pnis_pkg::FN_REMOVE, all1, 64'h8000_0000_0000_0000);
    send_request(pnis_pkg::FN_REMOVE, 64'd0, 64'd0);
    for (int i = 0; i < 70; i++) begin
      send_request(pnis_pkg::FN_ADD, 64'(1000 + 4 * i), 64'(1002 + 4 * i));
    end
    send_request(pnis_pkg::FN_ADD, 64'd1001, 64'd1005);
    send_request(pnis_pkg::FN_DROP, all1, all1);
    send_request(pnis_pkg::FN_REMOVE, all1, all1);

    wait (pending == 0);
    hold_off = 1;
    for (int i = 0; i < 600; i++) random_request();
    wait (pending == 0);
    repeat (20) @(negedge clk);
    for (int i = 0; i < 400; i++) random_request();
    sender_done = 1;
  end

  initial begin
    int t;
    wait (sender_done);
    wait (pending == 0);
    t = 0;
    while (t < 1000) begin
      @(posedge clk);
      t++;
    end
    if (fail_count == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule

[packet_number_interval_set.f]
rtl/pnis_pkg.sv
rtl/pnis_ram.sv
rtl/packet_number_interval_set.sv
rtl/pnis_checker.sv
verif/pnis_checker.sv
verif/tb_packet_number_interval_set.sv
